// ----- hw/rtl/bffa_pkg.sv -----
package bffa_pkg;

    localparam int WORD_BITS = 8;
    localparam int WORD_LSB  = 3;
    localparam int NEED_W    = 14;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

endpackage

// ----- hw/rtl/bffa_ram.sv -----
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/bitmap_first_fit_allocator.sv -----
// Allocate scans the bitmap words in order, then sets the run it found by a read
// and a write-back of each of its words; free clears its range the same way.
// The scan streams one 8-bit word per cycle from the bitmap RAM, which sets the rate.
// One item is in work at a time; a finished result waits in the output register.
// After reset the bitmap RAM is cleared word by word; no item is taken
// until the clearing pass ends.
module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int NUM_GRANULES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [15:0] size_bytes,
    input  logic [11:0] block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [11:0] granted_index
);

    localparam int DEPTH = NUM_GRANULES / WORD_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = ($clog2(NUM_GRANULES) + 1 > 13) ? $clog2(NUM_GRANULES) + 1 : 13;
    localparam int LW    = (GW > NEED_W) ? GW : NEED_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RRD  = 3'd3;
    localparam logic [2:0] S_RWR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW:0]   iss_addr_reg, iss_addr_next;
    logic          dat_vld_reg, dat_vld_next;
    logic [AW-1:0] dat_addr_reg, dat_addr_next;
    logic [LW-1:0] run_reg, run_next;
    logic [LW-1:0] need_reg, need_next;
    logic [GW-1:0] g_reg, g_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic          set_reg, set_next;
    logic          res_status_reg, res_status_next;
    logic [11:0]   res_index_reg, res_index_next;
    logic          out_valid_reg, out_valid_next;
    logic          status_reg, status_next;
    logic [11:0]   granted_reg, granted_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;

    logic [NEED_W-1:0] need_in;
    logic [LW-1:0]     scan_run;
    logic              hit;
    logic [2:0]        hit_pos;
    logic [GW-1:0]     end_g;
    logic [LW-1:0]     start_l;
    logic [2:0]        lo;
    logic [3:0]        avail;
    logic [3:0]        cnt;
    logic [3:0]        hi;
    word_t             mask;

    bffa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign need_in = NEED_W'(({1'b0, size_bytes} + 17'd7) >> WORD_LSB);

    // run of free bits through the current word
    always_comb
    begin
        scan_run = run_reg;
        hit      = 1'b0;
        hit_pos  = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (!hit)
            begin
                if (ram_rdata[j])
                begin
                    scan_run = '0;
                end
                else
                begin
                    scan_run = scan_run + LW'(1);
                end
                if (scan_run >= need_reg)
                begin
                    hit     = 1'b1;
                    hit_pos = 3'(j);
                end
            end
        end
    end

    assign end_g   = GW'({dat_addr_reg, hit_pos});
    assign start_l = LW'(end_g) + LW'(1) - need_reg;

    // bits of the current word that fall in the range
    assign lo    = g_reg[WORD_LSB-1:0];
    assign avail = 4'(WORD_BITS) - {1'b0, lo};
    assign cnt   = (rem_reg < LW'(avail)) ? rem_reg[3:0] : avail;
    assign hi    = {1'b0, lo} + cnt;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            mask[j] = (4'(j) >= {1'b0, lo}) && (4'(j) < hi);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        iss_addr_next   = iss_addr_reg;
        dat_vld_next    = 1'b0;
        dat_addr_next   = dat_addr_reg;
        run_next        = run_reg;
        need_next       = need_reg;
        g_next          = g_reg;
        rem_next        = rem_reg;
        set_next        = set_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        granted_next    = granted_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_raddr       = iss_addr_reg[AW-1:0];

        case (state_reg)
            S_CLR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = STATUS_OK;
                    res_index_next  = '0;
                    if (mode == MODE_FREE)
                    begin
                        g_next     = GW'(block_index);
                        rem_next   = LW'(need_in);
                        set_next   = 1'b0;
                        state_next = S_RRD;
                    end
                    else
                    begin
                        need_next     = (need_in == '0) ? LW'(1) : LW'(need_in);
                        iss_addr_next = '0;
                        run_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_addr_reg < (AW+1)'(DEPTH))
                begin
                    iss_addr_next = iss_addr_reg + (AW+1)'(1);
                    dat_vld_next  = 1'b1;
                    dat_addr_next = iss_addr_reg[AW-1:0];
                end
                if (dat_vld_reg)
                begin
                    run_next = scan_run;
                    if (hit)
                    begin
                        g_next         = GW'(start_l);
                        rem_next       = need_reg;
                        set_next       = 1'b1;
                        res_index_next = 12'(start_l);
                        dat_vld_next   = 1'b0;
                        state_next     = S_RRD;
                    end
                    else if (dat_addr_reg == AW'(DEPTH - 1))
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_RRD:
            begin
                ram_raddr = g_reg[AW+WORD_LSB-1:WORD_LSB];
                if ((rem_reg == '0) || (g_reg >= GW'(NUM_GRANULES)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RWR;
                end
            end
            S_RWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = g_reg[AW+WORD_LSB-1:WORD_LSB];
                ram_wdata  = set_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
                g_next     = {g_reg[GW-1:WORD_LSB] + (GW-WORD_LSB)'(1), 3'b000};
                rem_next   = rem_reg - LW'(cnt);
                state_next = S_RRD;
            end
            S_DONE:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    granted_next   = res_index_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            iss_addr_reg  <= '0;
            dat_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            iss_addr_reg  <= iss_addr_next;
            dat_vld_reg   <= dat_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_addr_reg   <= dat_addr_next;
        run_reg        <= run_next;
        need_reg       <= need_next;
        g_reg          <= g_next;
        rem_reg        <= rem_next;
        set_reg        <= set_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import bffa_pkg::*;
();

    localparam int NGRAN = 4096;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic        mode;
        logic [15:0] size_bytes;
        logic [11:0] block_index;
        logic        has_expected;
        logic        exp_status;
        logic [11:0] exp_index;
    } request_t;

    typedef struct packed {
        logic        status;
        logic [11:0] granted_index;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_ALLOC;
    logic [15:0] size_bytes = '0;
    logic [11:0] block_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [11:0] granted_index;

    bit      granule_used [NGRAN];
    grant_t  pending_grants [$];
    grant_t  typed_grants [$];
    bit      typed_valid [$];
    request_t directed_rows [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 10;
    int      recv_idle_pct = 52;
    bit      hold_off = 1'b0;

    bitmap_first_fit_allocator #(.NUM_GRANULES(NGRAN)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Apply one request to the local bitmap and return its result.
    function automatic grant_t allocate_or_free(input logic m, input logic [15:0] sz,
                                                input logic [11:0] idx);
        grant_t g;
        int need;
        int run;
        int start;
        g = '0;
        need = (int'(sz) + 7) / 8;
        if (m == MODE_FREE)
        begin
            for (int i = 0; i < need && int'(idx) + i < NGRAN; i++)
                granule_used[int'(idx) + i] = 1'b0;
            return g;
        end
        if (need == 0)
            need = 1;
        run = 0;
        for (int i = 0; i < NGRAN; i++)
        begin
            if (granule_used[i])
            begin
                run = 0;
                continue;
            end
            run++;
            if (run >= need)
            begin
                start = i + 1 - need;
                for (int k = start; k <= i; k++)
                    granule_used[k] = 1'b1;
                g.granted_index = start[11:0];
                return g;
            end
        end
        g.status = STATUS_NO_SPACE;
        return g;
    endfunction

    // Called at a falling edge; leaves valid high after the accepting edge.
    task automatic send_item(input logic m, input logic [15:0] sz, input logic [11:0] idx,
                             input bit has_exp, input grant_t exp_grant);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        size_bytes <= sz;
        block_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_grants.push_back(allocate_or_free(m, sz, idx));
        typed_valid.push_back(has_exp);
        typed_grants.push_back(exp_grant);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off while hold_off is set.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        grant_t want;
        grant_t typed;
        bit chk;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                report("unexpected item", {status, granted_index}, 0);
            end
            else
            begin
                want = pending_grants.pop_front();
                typed = typed_grants.pop_front();
                chk = typed_valid.pop_front();
                if (status !== want.status)
                    report("status", status, want.status);
                if (granted_index !== want.granted_index)
                    report("granted_index", granted_index, want.granted_index);
                if (chk && {status, granted_index} !== typed)
                    report("table entry", {status, granted_index}, typed);
            end
        end
    end

    function automatic request_t row(input logic m, input int sz, input int idx,
                                     input bit has_exp, input logic st, input int gi);
        request_t r;
        r.mode = m;
        r.size_bytes = sz[15:0];
        r.block_index = idx[11:0];
        r.has_expected = has_exp;
        r.exp_status = st;
        r.exp_index = gi[11:0];
        return r;
    endfunction

    task automatic random_item;
        int kind;
        int sz;
        kind = $urandom_range(99);
        if (kind < 5)
            sz = $urandom_range(65535);
        else if (kind < 10)
            sz = $urandom_range(32768, 30000);
        else if (kind < 60)
            sz = $urandom_range(64);
        else
            sz = $urandom_range(1024);
        if ($urandom_range(99) < 55)
            send_item(MODE_ALLOC, sz[15:0], 12'($urandom), 1'b0, '0);
        else
            send_item(MODE_FREE, sz[15:0], 12'($urandom), 1'b0, '0);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        directed_rows.push_back(row(MODE_ALLOC, 0, 4095, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 1, 0, 1, STATUS_OK, 1));
        directed_rows.push_back(row(MODE_ALLOC, 8, 0, 1, STATUS_OK, 2));
        directed_rows.push_back(row(MODE_ALLOC, 9, 0, 1, STATUS_OK, 3));
        directed_rows.push_back(row(MODE_ALLOC, 65535, 0, 1, STATUS_NO_SPACE, 0));
        directed_rows.push_back(row(MODE_ALLOC, 32768, 0, 1, STATUS_NO_SPACE, 0));
        directed_rows.push_back(row(MODE_FREE, 0, 0, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 16, 0, 0, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_FREE, 8, 1, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 8, 0, 1, STATUS_OK, 1));
        directed_rows.push_back(row(MODE_FREE, 65535, 0, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 32768, 0, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 0, 0, 1, STATUS_NO_SPACE, 0));
        directed_rows.push_back(row(MODE_FREE, 32768, 4095, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 8, 0, 1, STATUS_OK, 4095));
        directed_rows.push_back(row(MODE_FREE, 800, 4000, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 1000, 0, 0, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_FREE, 32760, 2730, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_FREE, 32768, 0, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 32768, 0, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_FREE, 43690, 1365, 1, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_ALLOC, 21845, 0, 0, STATUS_OK, 0));
        directed_rows.push_back(row(MODE_FREE, 65535, 0, 1, STATUS_OK, 0));

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].size_bytes,
                      directed_rows[i].block_index, directed_rows[i].has_expected,
                      {directed_rows[i].exp_status, directed_rows[i].exp_index});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 10;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off = 1'b1;
                fork
                    begin
                        // hold the output for a long stretch while items keep coming
                        repeat (2000) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_item();
        end

        drain();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_ram.sv
hw/rtl/bitmap_first_fit_allocator.sv
test/testbench.sv
